@@ hw/rtl/rc3_pkg.sv @@
`timescale 1ns / 1ps

package rc3_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Register indexes of the configuration port
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_ABS    = 3'd3;
  localparam logic [2:0] REG_KTOP   = 3'd4;
  localparam logic [2:0] REG_KMID   = 3'd5;
  localparam logic [2:0] REG_KBOT   = 3'd6;

  // Border modes
  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_REPL  = 2'd1;
  localparam logic [1:0] MODE_REFL  = 2'd2;
  localparam logic [1:0] MODE_R101  = 2'd3;

  // Tap select code that reads as zero
  localparam logic [1:0] SEL_ZERO   = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rc3_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } rc3_out_t;

  // Stage load enables shared by the lanes
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } rc3_ld_t;

  typedef logic [8:0][7:0]  rc3_taps_t;
  typedef logic [8:0][15:0] rc3_coefs_t;

endpackage

@@ hw/rtl/rgb_convolution_3x3_border_modes.sv @@
`timescale 1ns / 1ps

// 3x3 RGB convolution over a raster pixel stream with selectable borders.
// Input channel (in_valid/in_ready/in_data): one item per pixel in raster
// order; operation 1 is a drain step, and width+1 drain steps after the
// last pixel flush the frame. Output k leaves for input item k+width+1,
// and frame_last marks the final pixel of the frame.
// Configuration (cfg_valid/cfg_index/cfg_data) is always ready and must
// only be written while the pipeline is empty; a size write restarts the
// frame.
// Throughput: one item per clock unless a stalled receiver holds the flow,
// set by the line store access and the fully pipelined per-channel lanes.
// Pipeline: the accepting edge loads the line store read and tap selects,
// then multiply, row sums, full sum and the output register follow as
// registered stages before a result reaches out_valid.
// Reset clears the counters, the window and all pipeline valids; the line
// stores are not cleared. A stalled receiver holds the output register and
// back-pressure ripples stage by stage, so bubbles keep being absorbed.

module rgb_convolution_3x3_border_modes import rc3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rc3_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rc3_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // configuration registers
  logic [10:0]      width_r;
  logic [15:0]      height_r;
  logic [1:0]       mode_r;
  logic             abs_r;
  logic [2:0][47:0] krow_r;
  logic [10:0]      wval;

  assign cfg_ready = 1'b1;
  assign wval      = cfg_data[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1;
      height_r <= 16'd1;
      mode_r   <= MODE_R101;
      abs_r    <= 1'b0;
      krow_r   <= {48'd0, 48'h0000_1000_0000, 48'd0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          if (wval == 11'd0) begin
            width_r <= 11'd1;
          end else if (wval > 11'(MAX_WIDTH)) begin
            width_r <= 11'(MAX_WIDTH);
          end else begin
            width_r <= wval;
          end
        end
        REG_HEIGHT: height_r <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
        REG_MODE:   mode_r   <= cfg_data[1:0];
        REG_ABS:    abs_r    <= cfg_data[0];
        REG_KTOP:   krow_r[0] <= cfg_data;
        REG_KMID:   krow_r[1] <= cfg_data;
        REG_KBOT:   krow_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic acc, s1_leave;

  assign rdy_out  = !ov_r || out_ready;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign acc      = in_valid && rdy1;
  assign s1_leave = v1_r && rdy2;

  // frame counters
  logic [ADDR_W-1:0] c_r;
  logic [16:0]       r_r;
  logic [25:0]       em_r;
  logic [26:0]       total;
  logic              em_lt, is_re, is_rg, emit, last;
  logic [10:0]       c_inc;
  logic              restart_cfg;

  assign total       = {16'd0, width_r} * {11'd0, height_r};
  assign em_lt       = {1'b0, em_r} < total;
  assign is_re       = (c_r == '0) && (r_r >= 17'd2) && em_lt;
  assign is_rg       = (c_r != '0) && (r_r >= 17'd1) && em_lt;
  assign emit        = is_re || is_rg;
  assign last        = emit && (({1'b0, em_r} + 27'd1) == total);
  assign c_inc       = 11'(c_r) + 11'd1;
  assign restart_cfg = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n || restart_cfg) begin
      c_r  <= '0;
      r_r  <= '0;
      em_r <= '0;
    end else if (acc) begin
      if (last) begin
        c_r  <= '0;
        r_r  <= '0;
        em_r <= '0;
      end else begin
        if (emit) begin
          em_r <= em_r + 26'd1;
        end
        if (c_inc >= width_r) begin
          c_r <= '0;
          r_r <= r_r + 17'd1;
        end else begin
          c_r <= c_inc[ADDR_W-1:0];
        end
      end
    end
  end

  // border mapping to window row and column selects
  logic [16:0]     cy;
  logic            top_b, bot_b, left_b, right_b, h1, w1;
  logic [1:0]      co;
  logic [2:0][1:0] rs, cs;

  assign cy      = r_r - (is_re ? 17'd2 : 17'd1);
  assign top_b   = (cy == 17'd0);
  assign bot_b   = (cy == ({1'b0, height_r} - 17'd1));
  assign h1      = (height_r == 16'd1);
  assign w1      = (width_r == 11'd1);
  assign left_b  = is_re ? w1 : (c_r == ADDR_W'(1));
  assign right_b = is_re;
  assign co      = is_re ? 2'd2 : 2'd1;

  always_comb begin
    rs[1] = 2'd1;
    cs[1] = co;
    rs[0] = 2'd0;
    rs[2] = 2'd2;
    cs[0] = co - 2'd1;
    cs[2] = co + 2'd1;
    if (top_b) begin
      case (mode_r) inside
        MODE_ZERO: rs[0] = SEL_ZERO;
        MODE_REPL, MODE_REFL: rs[0] = 2'd1;
        default: rs[0] = h1 ? 2'd1 : 2'd2;
      endcase
    end
    if (bot_b) begin
      case (mode_r) inside
        MODE_ZERO: rs[2] = SEL_ZERO;
        MODE_REPL, MODE_REFL: rs[2] = 2'd1;
        default: rs[2] = h1 ? 2'd1 : 2'd0;
      endcase
    end
    if (left_b) begin
      case (mode_r) inside
        MODE_ZERO: cs[0] = SEL_ZERO;
        MODE_REPL, MODE_REFL: cs[0] = co;
        default: cs[0] = w1 ? co : co + 2'd1;
      endcase
    end
    if (right_b) begin
      case (mode_r) inside
        MODE_ZERO: cs[2] = SEL_ZERO;
        MODE_REPL, MODE_REFL: cs[2] = co;
        default: cs[2] = w1 ? co : co - 2'd1;
      endcase
    end
  end

  // stage 1: line store data arrives, window shifts
  logic [23:0]       px1_r;
  logic [ADDR_W-1:0] a1_r;
  logic              re1_r, emit1_r, last1_r;
  logic [2:0][1:0]   rs1_r, cs1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1_r   <= in_data.operation ? 24'd0
                 : {in_data.blue_in, in_data.green_in, in_data.red_in};
      a1_r    <= c_r;
      re1_r   <= is_re;
      emit1_r <= emit;
      last1_r <= last;
      rs1_r   <= rs;
      cs1_r   <= cs;
    end
  end

  logic [47:0] rd_data;

  rc3_line_store u_lines (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (c_r),
    .wr_en   (s1_leave),
    .wr_addr (a1_r),
    .wr_data ({rd_data[23:0], px1_r}),
    .rd_data (rd_data)
  );

  // window: [row][col], row 0 oldest, col 0 leftmost
  logic [2:0][2:0][23:0] win_r, win_sh, src;

  always_comb begin
    for (int row = 0; row < 3; row++) begin
      win_sh[row][0] = win_r[row][1];
      win_sh[row][1] = win_r[row][2];
    end
    win_sh[0][2] = rd_data[47:24];
    win_sh[1][2] = rd_data[23:0];
    win_sh[2][2] = px1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_leave) begin
      win_r <= win_sh;
    end
  end

  // right-edge results use the window before it shifts
  assign src = re1_r ? win_r : win_sh;

  rc3_taps_t  taps [3];
  rc3_coefs_t coefs;

  always_comb begin
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        coefs[ky*3+kx] = krow_r[2-ky][16*(2-kx) +: 16];
        for (int ch = 0; ch < 3; ch++) begin
          if ((rs1_r[ky] == SEL_ZERO) || (cs1_r[kx] == SEL_ZERO)) begin
            taps[ch][ky*3+kx] = 8'd0;
          end else begin
            taps[ch][ky*3+kx] = src[rs1_r[ky]][cs1_r[kx]][8*ch +: 8];
          end
        end
      end
    end
  end

  // valid and frame_last travel beside the lanes
  logic l2_r, l3_r, l4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= v1_r && emit1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) l2_r <= last1_r;
    if (rdy3) l3_r <= l2_r;
    if (rdy4) l4_r <= l3_r;
  end

  rc3_ld_t    ld;
  logic [7:0] res [3];

  assign ld = '{s2: rdy2, s3: rdy3, s4: rdy4};

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rc3_lane u_lane (
      .clk    (clk),
      .ld     (ld),
      .taps   (taps[ch]),
      .coefs  (coefs),
      .abs_en (abs_r),
      .result (res[ch])
    );
  end

  // merge the lanes into the output register
  rc3_out_t od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (rdy_out) begin
      ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      od_r <= '{red_out: res[0], green_out: res[1], blue_out: res[2], frame_last: l4_r};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

@@ hw/rtl/rc3_line_store.sv @@
`timescale 1ns / 1ps

module rc3_line_store import rc3_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [47:0]       wr_data,
  output logic [47:0]       rd_data
);

  // upper line in the high half, middle line in the low half
  logic [47:0] mem [MAX_WIDTH];
  logic [47:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, forwarding a write to the same word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rc3_lane.sv @@
`timescale 1ns / 1ps

module rc3_lane import rc3_pkg::*; (
  input  logic       clk,
  input  rc3_ld_t    ld,
  input  rc3_taps_t  taps,
  input  rc3_coefs_t coefs,
  input  logic       abs_en,
  output logic [7:0] result
);

  logic signed [24:0] prod_r [9];
  logic signed [26:0] psum_r [3];
  logic signed [28:0] sum_r;
  logic signed [29:0] mag;
  logic signed [29:0] rnd;

  // one multiplier per tap
  always_ff @(posedge clk) begin
    if (ld.s2) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= $signed({1'b0, taps[i]}) * $signed(coefs[i]);
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    if (ld.s3) begin
      for (int i = 0; i < 3; i++) begin
        psum_r[i] <= 27'(prod_r[3*i]) + 27'(prod_r[3*i+1]) + 27'(prod_r[3*i+2]);
      end
    end
  end

  // full sum
  always_ff @(posedge clk) begin
    if (ld.s4) begin
      sum_r <= 29'(psum_r[0]) + 29'(psum_r[1]) + 29'(psum_r[2]);
    end
  end

  // optional magnitude, round half up on Q.12, clamp to a byte
  always_comb begin
    mag = 30'(sum_r);
    if (abs_en && mag < 0) begin
      mag = -mag;
    end
    rnd = mag + 30'sd2048;
    if (mag < 0) begin
      result = 8'd0;
    end else if (rnd[29:12] > 18'd255) begin
      result = 8'd255;
    end else begin
      result = rnd[19:12];
    end
  end

endmodule

@@ hw/rtl/rc3_checker.sv @@
`timescale 1ns / 1ps

module rc3_checker import rc3_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input rc3_out_t out_data,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // an empty output register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // configuration is never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind rgb_convolution_3x3_border_modes rc3_checker u_rc3_checker (.*);
